/* hw/rtl/vdps_pkg.sv */
// vdps_pkg: shared types and constants for the variable density poisson stencil block
// used by every module under hw/rtl; depends on nothing
`default_nettype none
package vdps_pkg;

  localparam int unsigned NUM_FACES      = 6;
  localparam int unsigned DENS_W         = 32;
  localparam int unsigned SUM_W          = DENS_W + 1;
  localparam int unsigned INV_W          = 32;
  localparam int unsigned COEF_W         = 63;
  localparam int unsigned CENTRE_W       = 64;
  localparam int unsigned DVD_W          = INV_W + SUM_W;   // inv scaled by 2^33
  localparam int unsigned DIV_STEPS      = DVD_W;           // one quotient bit per step
  localparam int unsigned CNT_W          = 7;
  localparam int unsigned CELLS_W        = 11;
  localparam int unsigned MASK_W         = 6;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned MAX_CELLS_DEF  = 1024;
  localparam int unsigned SIZE_W         = 14;              // holds any size up to 4096

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELLS_X   = 3'd0,
    REG_CELLS_Y   = 3'd1,
    REG_CELLS_Z   = 3'd2,
    REG_PHYS_MASK = 3'd3,
    REG_OUT_MASK  = 3'd4,
    REG_INV_DX    = 3'd5,
    REG_INV_DY    = 3'd6,
    REG_INV_DZ    = 3'd7
  } cfg_reg_t;

  // boundary mask bits
  localparam int unsigned BIT_ZMINUS = 0;
  localparam int unsigned BIT_ZPLUS  = 1;
  localparam int unsigned BIT_YMINUS = 2;
  localparam int unsigned BIT_YPLUS  = 3;
  localparam int unsigned BIT_XMINUS = 4;
  localparam int unsigned BIT_XPLUS  = 5;

  typedef struct packed {
    logic [DENS_W-1:0] dens_here;
    logic [DENS_W-1:0] dens_below;
    logic [DENS_W-1:0] dens_south;
    logic [DENS_W-1:0] dens_west;
    logic [DENS_W-1:0] dens_east;
    logic [DENS_W-1:0] dens_north;
    logic [DENS_W-1:0] dens_above;
  } in_beat_t;

  typedef struct packed {
    logic [COEF_W-1:0]          coef_below;
    logic [COEF_W-1:0]          coef_south;
    logic [COEF_W-1:0]          coef_west;
    logic signed [CENTRE_W-1:0] coef_centre;
    logic [COEF_W-1:0]          coef_east;
    logic [COEF_W-1:0]          coef_north;
    logic [COEF_W-1:0]          coef_above;
    logic                       box_done;
    logic                       zero_sum_seen;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic step;
  } lane_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/variable_density_poisson_stencil_coefs.sv */
// variable_density_poisson_stencil_coefs: top level, config registers, position counters,
// six divider lanes, merge and output register; depends on vdps_pkg, vdps_lane, vdps_merge
`default_nettype none
// one beat in is one grid cell in x-fastest raster order with its own and six neighbour
// densities; one beat out carries the six face coefficients 2*inv_sq/(own+neighbour) in
// Q47.16, the centre term and two flags. each beat goes from accept through a load into
// the lanes, the bit-serial restoring divide that all six lanes run side by side, and the
// centre merge into the output register. the input side takes a new beat as soon as the
// lanes are free, even while the last result still waits on out_stall. config writes are
// taken any time and must land only while idle.
module variable_density_poisson_stencil_coefs #(
  parameter int unsigned MAX_CELLS_PER_AXIS = vdps_pkg::MAX_CELLS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire vdps_pkg::in_beat_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output vdps_pkg::out_beat_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [vdps_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [vdps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vdps_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_CELLS_PER_AXIS);

  typedef enum logic [1:0] {IDLE, RUN, FIN} state_t;

  // config registers
  logic [CELLS_W-1:0] cells_x_r, cells_y_r, cells_z_r;
  logic [MASK_W-1:0]  phys_r, outflow_r;
  logic [INV_W-1:0]   inv_dx_r, inv_dy_r, inv_dz_r;

  logic [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_FACES-1:0] excl_r;
  logic             box_done_r;
  out_beat_t        out_r;
  logic             out_valid_r;

  logic accept, out_free, load_out;
  logic last_x, last_y, last_z;
  logic [MASK_W-1:0] corr;
  logic [NUM_FACES-1:0] excl_nxt;
  lane_ctrl_t lane_ctrl;

  logic [NUM_FACES-1:0][COEF_W-1:0] coefs;
  logic [NUM_FACES-1:0]             zeros;
  logic [NUM_FACES-1:0][DENS_W-1:0] nbr;
  logic [NUM_FACES-1:0][INV_W-1:0]  inv_sel;
  logic signed [CENTRE_W-1:0]       centre;

  // clamp a configured size to 1..MAX and test for the last index
  function automatic logic is_last(input logic [CELLS_W-1:0] n, input logic [POS_W-1:0] p);
    logic [SIZE_W-1:0] eff;
    eff = {{(SIZE_W-CELLS_W){1'b0}}, n};
    if (eff == '0) eff = SIZE_W'(1);
    else if (eff > SIZE_W'(MAX_CELLS_PER_AXIS)) eff = SIZE_W'(MAX_CELLS_PER_AXIS);
    return {{(SIZE_W-POS_W){1'b0}}, p} >= eff - SIZE_W'(1);
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = state_r != IDLE;
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = state_r == FIN && out_free;

  assign last_x = is_last(cells_x_r, pos_x_r);
  assign last_y = is_last(cells_y_r, pos_y_r);
  assign last_z = is_last(cells_z_r, pos_z_r);
  assign corr   = phys_r & ~outflow_r;

  // lane order: below, south, west, east, north, above
  assign excl_nxt[0] = (pos_z_r == '0) && corr[BIT_ZMINUS];
  assign excl_nxt[1] = (pos_y_r == '0) && corr[BIT_YMINUS];
  assign excl_nxt[2] = (pos_x_r == '0) && corr[BIT_XMINUS];
  assign excl_nxt[3] = last_x && corr[BIT_XPLUS];
  assign excl_nxt[4] = last_y && corr[BIT_YPLUS];
  assign excl_nxt[5] = last_z && corr[BIT_ZPLUS];

  assign nbr = {in_data.dens_above, in_data.dens_north, in_data.dens_east,
                in_data.dens_west,  in_data.dens_south, in_data.dens_below};
  assign inv_sel = {inv_dz_r, inv_dy_r, inv_dx_r, inv_dx_r, inv_dy_r, inv_dz_r};

  assign lane_ctrl.start = accept;
  assign lane_ctrl.step  = state_r == RUN;

  for (genvar k = 0; k < NUM_FACES; k++) begin : g_lane
    vdps_lane u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .inv    (inv_sel[k]),
      .dens_a (in_data.dens_here),
      .dens_b (nbr[k]),
      .coef   (coefs[k]),
      .zero   (zeros[k])
    );
  end

  vdps_merge u_merge (
    .coefs  (coefs),
    .excl   (excl_r),
    .centre (centre)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r <= CELLS_W'(1);
      cells_y_r <= CELLS_W'(1);
      cells_z_r <= CELLS_W'(1);
      phys_r    <= '0;
      outflow_r <= '0;
      inv_dx_r  <= INV_W'(1);
      inv_dy_r  <= INV_W'(1);
      inv_dz_r  <= INV_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_CELLS_X:   cells_x_r <= cfg_wdata[CELLS_W-1:0];
        REG_CELLS_Y:   cells_y_r <= cfg_wdata[CELLS_W-1:0];
        REG_CELLS_Z:   cells_z_r <= cfg_wdata[CELLS_W-1:0];
        REG_PHYS_MASK: phys_r    <= cfg_wdata[MASK_W-1:0];
        REG_OUT_MASK:  outflow_r <= cfg_wdata[MASK_W-1:0];
        REG_INV_DX:    inv_dx_r  <= cfg_wdata[INV_W-1:0];
        REG_INV_DY:    inv_dy_r  <= cfg_wdata[INV_W-1:0];
        REG_INV_DZ:    inv_dz_r  <= cfg_wdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, position counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      cnt_r       <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      pos_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        IDLE: begin
          if (accept) begin
            state_r <= RUN;
            cnt_r   <= '0;
            // raster advance, x fastest
            if (last_x) begin
              pos_x_r <= '0;
              if (last_y) begin
                pos_y_r <= '0;
                pos_z_r <= last_z ? '0 : pos_z_r + POS_W'(1);
              end else begin
                pos_y_r <= pos_y_r + POS_W'(1);
              end
            end else begin
              pos_x_r <= pos_x_r + POS_W'(1);
            end
          end
        end
        RUN: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_r <= FIN;
        end
        FIN: begin
          if (out_free) begin
            state_r     <= IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  // per-cell side info and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      excl_r     <= excl_nxt;
      box_done_r <= last_x && last_y && last_z;
    end
    if (load_out) begin
      out_r.coef_below    <= coefs[0];
      out_r.coef_south    <= coefs[1];
      out_r.coef_west     <= coefs[2];
      out_r.coef_centre   <= centre;
      out_r.coef_east     <= coefs[3];
      out_r.coef_north    <= coefs[4];
      out_r.coef_above    <= coefs[5];
      out_r.box_done      <= box_done_r;
      out_r.zero_sum_seen <= |zeros;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

/* hw/rtl/vdps_lane.sv */
// vdps_lane: one face lane, density sum and bit-serial restoring divide
// depends on vdps_pkg
`default_nettype none
module vdps_lane (
  input  wire logic                        clk,
  input  wire vdps_pkg::lane_ctrl_t        ctrl,
  input  wire logic [vdps_pkg::INV_W-1:0]  inv,
  input  wire logic [vdps_pkg::DENS_W-1:0] dens_a,
  input  wire logic [vdps_pkg::DENS_W-1:0] dens_b,
  output logic [vdps_pkg::COEF_W-1:0]      coef,
  output logic                             zero
);
  import vdps_pkg::*;

  localparam int unsigned REM_W = SUM_W + 1;

  logic [SUM_W-1:0]  sum_w;
  logic [SUM_W-1:0]  sum_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [REM_W-1:0]  rem_r, rem_sh, rem_nxt;
  logic [COEF_W-1:0] q_r;
  logic              qbit;
  logic              sat_r, zero_r;

  assign sum_w  = {1'b0, dens_a} + {1'b0, dens_b};
  assign rem_sh = {rem_r[REM_W-2:0], dvd_r[DVD_W-1]};
  assign qbit   = rem_sh >= {1'b0, sum_r};
  assign rem_nxt = qbit ? rem_sh - {1'b0, sum_r} : rem_sh;

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      sum_r  <= sum_w;
      dvd_r  <= {inv, {SUM_W{1'b0}}};
      rem_r  <= '0;
      q_r    <= '0;
      zero_r <= sum_w == '0;
      // quotient would reach 2^63
      sat_r  <= (sum_w == '0) ||
                ({{(COEF_W-INV_W){1'b0}}, inv} >= {sum_w, {(COEF_W-SUM_W){1'b0}}});
    end else if (ctrl.step) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[COEF_W-2:0], qbit};
    end
  end

  assign coef = sat_r ? {COEF_W{1'b1}} : q_r;
  assign zero = zero_r;
endmodule
`default_nettype wire

/* hw/rtl/vdps_merge.sv */
// vdps_merge: combines the six lane coefficients into the clamped centre term
// depends on vdps_pkg
`default_nettype none
module vdps_merge (
  input  wire logic [vdps_pkg::NUM_FACES-1:0][vdps_pkg::COEF_W-1:0] coefs,
  input  wire logic [vdps_pkg::NUM_FACES-1:0]                       excl,
  output logic signed [vdps_pkg::CENTRE_W-1:0]                      centre
);
  import vdps_pkg::*;

  localparam int unsigned ACC_W = COEF_W + 3;

  logic [NUM_FACES-1:0][ACC_W-1:0] term;
  logic [ACC_W-1:0]    pair0, pair1, pair2;
  logic [ACC_W-1:0]    acc;
  logic [CENTRE_W-1:0] mag;

  always_comb begin
    for (int k = 0; k < NUM_FACES; k++) begin
      term[k] = excl[k] ? '0 : {{(ACC_W-COEF_W){1'b0}}, coefs[k]};
    end
    // balanced adder tree, three levels deep
    pair0 = term[0] + term[1];
    pair1 = term[2] + term[3];
    pair2 = term[4] + term[5];
    acc   = (pair0 + pair1) + pair2;
    // clamp at 2^63, the most negative centre
    if (acc > {{(ACC_W-CENTRE_W){1'b0}}, 1'b1, {(CENTRE_W-1){1'b0}}})
      mag = {1'b1, {(CENTRE_W-1){1'b0}}};
    else
      mag = acc[CENTRE_W-1:0];
    centre = signed'(~mag + {{(CENTRE_W-1){1'b0}}, 1'b1});
  end
endmodule
`default_nettype wire

/* hw/rtl/vdps_checker.sv */
// vdps_checker: port-level assertions for the stencil coefficient block, bound to the top
// depends on vdps_pkg and variable_density_poisson_stencil_coefs
`default_nettype none
module vdps_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire vdps_pkg::out_beat_t out_data
);
  import vdps_pkg::*;

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // an accepted cell occupies the lanes, so the input stalls in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while lanes busy");

  // centre term is never positive
  a_centre_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.coef_centre[CENTRE_W-1] || out_data.coef_centre == '0)
    else $error("positive centre coefficient");

  // a zero density sum shows up as a saturated face
  a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_sum_seen |->
      (&out_data.coef_below) || (&out_data.coef_south) || (&out_data.coef_west) ||
      (&out_data.coef_east) || (&out_data.coef_north) || (&out_data.coef_above))
    else $error("zero sum flag without saturated face");
endmodule

bind variable_density_poisson_stencil_coefs vdps_checker u_vdps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
